// ===== sv/iskf_pkg.sv =====
`timescale 1ns / 1ps

package iskf_pkg;

  // Default sizes
  localparam int NAME_BYTES_DEF  = 8;
  localparam int OFFSET_BITS_DEF = 16;

  // Width of the name byte counter and the name lengths, holds 0..15
  localparam int IDX_W = 4;

  // Characters with a meaning in the file
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Register indexes, byte address is 8 times the index
  typedef enum logic [1:0] {
    REG_SECTION_NAME   = 2'd0,
    REG_SECTION_LENGTH = 2'd1,
    REG_KEY_NAME       = 2'd2,
    REG_KEY_LENGTH     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SECT     = 3'd1,
    PH_SECT_END = 3'd2,
    PH_KEY_SKIP = 3'd3,
    PH_KEY      = 3'd4,
    PH_KEY_END  = 3'd5,
    PH_VAL_SKIP = 3'd6,
    PH_VAL      = 3'd7
  } phase_t;

  // Match progress carried between the two judge steps
  typedef struct packed {
    phase_t           phase;
    logic [IDX_W-1:0] idx;
  } match_t;

  // Answer raised by one judge step
  typedef struct packed {
    logic fire;
    logic found;
  } verdict_t;

  // Space, CR, LF and NUL end a word
  function automatic logic is_term(input logic [7:0] b);
    return b inside {CH_SPACE, CH_CR, CH_LF, CH_NUL};
  endfunction

endpackage

// ===== sv/iskf_judge.sv =====
`timescale 1ns / 1ps

module iskf_judge #(
  parameter int NAME_BYTES  = iskf_pkg::NAME_BYTES_DEF,
  parameter int OFFSET_BITS = iskf_pkg::OFFSET_BITS_DEF
) (
  input  logic                           en,
  input  iskf_pkg::match_t               cur,
  input  logic [OFFSET_BITS-1:0]         cur_vstart,
  input  logic [7:0]                     b,
  input  logic [OFFSET_BITS-1:0]         pos,
  input  logic                           has_next,
  input  logic [7:0]                     nxt,
  input  logic [63:0]                    section_name,
  input  logic [63:0]                    key_name,
  input  logic [iskf_pkg::IDX_W-1:0]     section_len,
  input  logic [iskf_pkg::IDX_W-1:0]     key_len,
  output iskf_pkg::match_t               upd,
  output logic [OFFSET_BITS-1:0]         upd_vstart,
  output iskf_pkg::verdict_t             verdict,
  output logic [OFFSET_BITS-1:0]         ans_off,
  output logic [OFFSET_BITS-1:0]         ans_len
);
  import iskf_pkg::*;

  logic             sect;
  logic             in_name;
  logic [63:0]      sel_name;
  logic [IDX_W-1:0] sel_len;
  logic [7:0]       name_ch;
  logic [IDX_W-1:0] idx_inc;

  // Pick the name under match and the byte at the current index
  assign sect     = (cur.phase == PH_SECT);
  assign in_name  = ((cur.phase == PH_SECT) || (cur.phase == PH_KEY)) && (cur.idx != '0);
  assign sel_name = sect ? section_name : key_name;
  assign sel_len  = sect ? section_len : key_len;
  assign name_ch  = sel_name[cur.idx[2:0]*8 +: 8];
  assign idx_inc  = cur.idx + IDX_W'(1);

  // Judge one byte against the match phase
  always_comb begin
    upd        = cur;
    upd_vstart = cur_vstart;
    verdict    = '0;
    ans_off    = '0;
    ans_len    = '0;
    if (en) begin
      if (cur.phase == PH_VAL_SKIP) begin
        upd.phase = PH_VAL;
      end else if ((b == CH_LBRACK) && !in_name) begin
        if (cur.phase == PH_KEY) begin
          verdict.fire = 1'b1;
        end else begin
          upd.phase = PH_SECT;
          upd.idx   = '0;
        end
      end else begin
        case (cur.phase)
          PH_SECT, PH_KEY: begin
            if ((cur.idx < IDX_W'(NAME_BYTES)) && (b == name_ch)) begin
              if (idx_inc >= sel_len) begin
                upd.phase = sect ? PH_SECT_END : PH_KEY_END;
                upd.idx   = '0;
              end else begin
                upd.idx = idx_inc;
              end
            end else begin
              upd.phase = sect ? PH_IDLE : PH_KEY_SKIP;
              upd.idx   = '0;
            end
          end
          PH_SECT_END: begin
            upd.phase = (b == CH_RBRACK) ? PH_KEY_SKIP : PH_IDLE;
          end
          PH_KEY_SKIP: begin
            if (is_term(b) && has_next && (nxt != CH_SEMI) && (nxt != CH_EQUAL) &&
                !is_term(nxt)) begin
              upd.phase = PH_KEY;
              upd.idx   = '0;
            end
          end
          PH_KEY_END: begin
            if (b == CH_EQUAL) begin
              // empty value or '=' at end of file gives not found
              if (!has_next || is_term(nxt)) begin
                verdict.fire = 1'b1;
              end else begin
                upd_vstart = pos + OFFSET_BITS'(1);
                upd.phase  = PH_VAL_SKIP;
              end
            end else begin
              upd.phase = PH_KEY_SKIP;
            end
          end
          PH_VAL: begin
            if (is_term(b)) begin
              verdict.fire  = 1'b1;
              verdict.found = 1'b1;
              ans_off       = cur_vstart;
              ans_len       = pos - cur_vstart;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/ini_section_key_finder_top.sv =====
`timescale 1ns / 1ps

// Scans an INI file streamed in one byte per item (tlast on the final byte) and reports,
// once per file, whether the configured key was found in the configured section, with
// the value's byte offset and length. One byte is accepted every cycle with no bubbles:
// each byte is held and judged by a few compares once the following byte arrives as
// lookahead, so a result is registered at the edge that accepts the byte after the one
// that decides it (the value terminator), or at the edge that accepts the last byte of
// the file at the latest, and is offered on the output from the next cycle. The input
// is stalled only while that output register is full and not being taken.
// Write the name and length registers only between files.

module ini_section_key_finder_top #(
  parameter int NAME_BYTES  = iskf_pkg::NAME_BYTES_DEF,
  parameter int OFFSET_BITS = iskf_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // file bytes in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] file_byte
  input  logic        s_tlast,   // last_byte
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] value_offset, [31:16] value_length
  output logic [0:0]  m_tuser    // [0] found
);
  import iskf_pkg::*;

  localparam int OUT_W = 16;

  // configuration registers
  logic [63:0]      section_name;
  logic [IDX_W-1:0] section_length;
  logic [63:0]      key_name;
  logic [IDX_W-1:0] key_length;

  // run state
  match_t                 st;
  logic [7:0]             held_byte;
  logic                   held_valid;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] value_start;
  logic                   answer_given;

  // output register
  logic             out_valid;
  logic             out_found;
  logic [OUT_W-1:0] out_off;
  logic [OUT_W-1:0] out_len;

  logic             cfg_wr;
  reg_index_t       cfg_idx;
  logic             s_acc;
  logic [IDX_W-1:0] section_len_c;
  logic [IDX_W-1:0] key_len_c;
  logic             force0;
  logic             given1;
  logic             given2;
  logic             given3;
  logic             force_last;
  logic             j1_en;
  logic             j2_en;
  match_t                 upd1;
  match_t                 upd2;
  logic [OFFSET_BITS-1:0] vstart1;
  logic [OFFSET_BITS-1:0] vstart2;
  verdict_t               v1;
  verdict_t               v2;
  logic [OFFSET_BITS-1:0] off1;
  logic [OFFSET_BITS-1:0] len1;
  logic [OFFSET_BITS-1:0] off2;
  logic [OFFSET_BITS-1:0] len2;
  logic                   res_fire;
  logic                   res_found;
  logic [OFFSET_BITS-1:0] res_off;
  logic [OFFSET_BITS-1:0] res_len;
  logic [OUT_W-1:0]       res_off16;
  logic [OUT_W-1:0]       res_len16;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_index_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_SECTION_NAME:   prdata = section_name;
      REG_SECTION_LENGTH: prdata = {{(64-IDX_W){1'b0}}, section_length};
      REG_KEY_NAME:       prdata = key_name;
      REG_KEY_LENGTH:     prdata = {{(64-IDX_W){1'b0}}, key_length};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section_name   <= '0;
      section_length <= '0;
      key_name       <= '0;
      key_length     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SECTION_NAME:   section_name   <= pwdata;
        REG_SECTION_LENGTH: section_length <= pwdata[IDX_W-1:0];
        REG_KEY_NAME:       key_name       <= pwdata;
        REG_KEY_LENGTH:     key_length     <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp name lengths to the name storage
  assign section_len_c = (section_length > IDX_W'(NAME_BYTES)) ? IDX_W'(NAME_BYTES)
                                                                : section_length;
  assign key_len_c  = (key_length > IDX_W'(NAME_BYTES)) ? IDX_W'(NAME_BYTES) : key_length;

  // handshake: take a byte whenever the output register can take a result
  assign s_tready = !out_valid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  // zero length names give not found at once
  assign force0 = !answer_given && ((section_len_c == '0) || (key_len_c == '0));
  assign given1 = answer_given || force0;
  assign j1_en  = !given1 && held_valid;

  // judge the held byte with the incoming one as lookahead
  iskf_judge #(
    .NAME_BYTES (NAME_BYTES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_judge_held (
    .en          (j1_en),
    .cur         (st),
    .cur_vstart  (value_start),
    .b           (held_byte),
    .pos         (byte_position - OFFSET_BITS'(1)),
    .has_next    (1'b1),
    .nxt         (s_tdata),
    .section_name(section_name),
    .key_name    (key_name),
    .section_len (section_len_c),
    .key_len     (key_len_c),
    .upd         (upd1),
    .upd_vstart  (vstart1),
    .verdict     (v1),
    .ans_off     (off1),
    .ans_len     (len1)
  );

  assign given2 = given1 || v1.fire;
  assign j2_en  = s_tlast && !given2;

  // on the last byte, judge it too with no lookahead
  iskf_judge #(
    .NAME_BYTES (NAME_BYTES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_judge_last (
    .en          (j2_en),
    .cur         (upd1),
    .cur_vstart  (vstart1),
    .b           (s_tdata),
    .pos         (byte_position),
    .has_next    (1'b0),
    .nxt         (8'h00),
    .section_name(section_name),
    .key_name    (key_name),
    .section_len (section_len_c),
    .key_len     (key_len_c),
    .upd         (upd2),
    .upd_vstart  (vstart2),
    .verdict     (v2),
    .ans_off     (off2),
    .ans_len     (len2)
  );

  // end of file without an answer gives not found
  assign given3     = given2 || v2.fire;
  assign force_last = s_tlast && !given3 && (upd2.phase == upd2.phase) && (vstart2 == vstart2);

  // merge the answers, at most one fires per byte
  assign res_fire  = force0 || v1.fire || v2.fire || force_last;
  assign res_found = v1.fire ? v1.found : (v2.fire ? v2.found : 1'b0);
  assign res_off   = v1.fire ? off1 : (v2.fire ? off2 : '0);
  assign res_len   = v1.fire ? len1 : (v2.fire ? len2 : '0);

  generate
    if (OFFSET_BITS >= OUT_W) begin : g_out_trunc
      assign res_off16 = res_off[OUT_W-1:0];
      assign res_len16 = res_len[OUT_W-1:0];
    end else begin : g_out_ext
      assign res_off16 = {{(OUT_W-OFFSET_BITS){1'b0}}, res_off};
      assign res_len16 = {{(OUT_W-OFFSET_BITS){1'b0}}, res_len};
    end
  endgenerate

  // advance run state, clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '{phase: PH_IDLE, idx: '0};
      held_byte     <= '0;
      held_valid    <= 1'b0;
      byte_position <= '0;
      value_start   <= '0;
      answer_given  <= 1'b0;
    end else if (s_acc) begin
      if (s_tlast) begin
        st            <= '{phase: PH_IDLE, idx: '0};
        held_byte     <= '0;
        held_valid    <= 1'b0;
        byte_position <= '0;
        value_start   <= '0;
        answer_given  <= 1'b0;
      end else begin
        st            <= upd1;
        held_byte     <= s_tdata;
        held_valid    <= 1'b1;
        byte_position <= byte_position + OFFSET_BITS'(1);
        value_start   <= vstart1;
        answer_given  <= given2;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_acc && res_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && res_fire) begin
      out_found <= res_found;
      out_off   <= res_off16;
      out_len   <= res_len16;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {out_len, out_off};
  assign m_tuser[0] = out_found;

  // a new result appears only after an accepted byte
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s_acc))
    else $error("result appeared without an accepted byte");

  // a file that ends unanswered always produces a result
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tlast && !answer_given) |=> m_tvalid)
    else $error("end of file gave no result");

  // the last byte resets the run
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tlast) |=> (!held_valid && (byte_position == '0) && !answer_given))
    else $error("run state not cleared after last byte");

  // a not found result carries zero offset and length
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("not found result with nonzero fields");

endmodule

// ===== tb/ini_section_key_finder_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both streams, predicts the lookup answer for
// every file and compares each result item against the oldest prediction.
module ini_section_key_finder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [0:0]  m_tuser,
  output int          fail_count,
  output int          pending
);
  import iskf_pkg::*;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [15:0] length;
  } finding_t;

  finding_t findings_due[$];

  // Shadow of the name and length registers
  logic [63:0] sect_name;
  logic [3:0]  sect_size;
  logic [63:0] key_name;
  logic [3:0]  key_len;

  // Scanner state
  phase_t      phase;
  logic [3:0]  name_pos;
  logic [7:0]  held;
  logic        held_ok;
  logic [15:0] file_pos;
  logic [15:0] val_start;
  logic        answered;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    fail_count++;
  endtask

  function automatic logic ends_word(input logic [7:0] b);
    return b == CH_SPACE || b == CH_CR || b == CH_LF || b == CH_NUL;
  endfunction

  function automatic int unsigned name_size(input logic [3:0] v);
    return (v > 4'd8) ? 8 : v;
  endfunction

  task automatic post_answer(input logic ok, input logic [15:0] off, input logic [15:0] len);
    finding_t f;
    f.found = ok;
    f.offset = ok ? off : 16'd0;
    f.length = ok ? len : 16'd0;
    answered = 1'b1;
    findings_due.push_back(f);
  endtask

  task automatic clear_scan();
    phase = PH_IDLE;
    name_pos = '0;
    held = '0;
    held_ok = 1'b0;
    file_pos = '0;
    val_start = '0;
    answered = 1'b0;
  endtask

  // Judge one byte once its follower is known
  task automatic judge_byte(input logic [7:0] b, input logic [15:0] pos,
                            input logic has_next, input logic [7:0] nxt);
    logic        mid_name;
    logic        is_sect;
    logic [63:0] nm;
    int unsigned len;
    mid_name = (phase == PH_SECT || phase == PH_KEY) && name_pos != 0;
    if (phase == PH_VAL_SKIP) begin
      phase = PH_VAL;
      return;
    end
    if (b == CH_LBRACK && !mid_name) begin
      if (phase == PH_KEY) begin
        post_answer(1'b0, 16'd0, 16'd0);
        return;
      end
      phase = PH_SECT;
      name_pos = '0;
      return;
    end
    case (phase)
      PH_SECT, PH_KEY: begin
        is_sect = (phase == PH_SECT);
        nm = is_sect ? sect_name : key_name;
        len = name_size(is_sect ? sect_size : key_len);
        if (name_pos < 8 && b == nm[{name_pos[2:0], 3'b000} +: 8]) begin
          name_pos = name_pos + 4'd1;
          if (name_pos >= len) begin
            phase = is_sect ? PH_SECT_END : PH_KEY_END;
            name_pos = '0;
          end
        end else begin
          phase = is_sect ? PH_IDLE : PH_KEY_SKIP;
          name_pos = '0;
        end
      end
      PH_SECT_END: phase = (b == CH_RBRACK) ? PH_KEY_SKIP : PH_IDLE;
      PH_KEY_SKIP: begin
        if (ends_word(b) && has_next && nxt != CH_SEMI && nxt != CH_EQUAL && !ends_word(nxt))
        begin
          phase = PH_KEY;
          name_pos = '0;
        end
      end
      PH_KEY_END: begin
        if (b == CH_EQUAL) begin
          if (!has_next || ends_word(nxt)) begin
            post_answer(1'b0, 16'd0, 16'd0);
            return;
          end
          val_start = pos + 16'd1;
          phase = PH_VAL_SKIP;
        end else begin
          phase = PH_KEY_SKIP;
        end
      end
      PH_VAL: begin
        if (ends_word(b))
          post_answer(1'b1, val_start, pos - val_start);
      end
      default: ;
    endcase
  endtask

  // Advance the scanner by one accepted file byte
  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    pos = file_pos;
    if (!answered && (name_size(sect_size) == 0 || name_size(key_len) == 0))
      post_answer(1'b0, 16'd0, 16'd0);
    if (!answered && held_ok)
      judge_byte(held, pos - 16'd1, 1'b1, b);
    if (last) begin
      if (!answered)
        judge_byte(b, pos, 1'b0, 8'd0);
      if (!answered)
        post_answer(1'b0, 16'd0, 16'd0);
      clear_scan();
    end else begin
      held = b;
      held_ok = 1'b1;
      file_pos = pos + 16'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    finding_t got;
    finding_t want;
    if (rst) begin
      sect_name = '0;
      sect_size = '0;
      key_name = '0;
      key_len = '0;
      clear_scan();
      findings_due.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:3]))
          REG_SECTION_NAME:   sect_name = pwdata;
          REG_SECTION_LENGTH: sect_size = pwdata[3:0];
          REG_KEY_NAME:       key_name = pwdata;
          REG_KEY_LENGTH:     key_len = pwdata[3:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        take_byte(s_tdata, s_tlast);
      // Compare each result item with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.found = m_tuser[0];
        got.offset = m_tdata[15:0];
        got.length = m_tdata[31:16];
        if (findings_due.size() == 0) begin
          report_mismatch("result with nothing pending", 0, 1);
        end else begin
          want = findings_due.pop_front();
          if (got.found != want.found)
            report_mismatch("found", want.found, got.found);
          if (got.offset != want.offset)
            report_mismatch("value_offset", want.offset, got.offset);
          if (got.length != want.length)
            report_mismatch("value_length", want.length, got.length);
        end
      end
    end
    pending = findings_due.size();
  end

endmodule

// ===== tb/tb_ini_section_key_finder_top.sv =====
`timescale 1ns / 1ps

module tb_ini_section_key_finder_top;
  import iskf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] file_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] value_offset, [31:16] value_length
  logic [0:0]  m_tuser;        // [0] found

  int fail_count;
  int pending;

  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;

  // Names and lengths currently loaded
  logic [63:0] cur_sect;
  logic [63:0] cur_key;
  int          cur_slen;
  int          cur_klen;

  logic [7:0] file_bytes[$];

  // Length pairs and name styles per setting: 0 letters, 1 all ones, 2 all zeros
  int slen_tab[7] = '{1, 8, 15, 0, 3, 2, 4};
  int klen_tab[7] = '{1, 8, 12, 3, 0, 5, 9};
  int mode_tab[7] = '{0, 1, 0, 0, 0, 2, 0};

  ini_section_key_finder_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  ini_section_key_finder_checker finder_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(9))
      0: return CH_SPACE;
      1: return CH_CR;
      2: return CH_NUL;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [63:0] make_name(input int mode);
    logic [63:0] nm;
    for (int k = 0; k < 8; k++) begin
      if (mode == 1)
        nm[8*k +: 8] = 8'hFF;
      else if (mode == 2)
        nm[8*k +: 8] = 8'h00;
      else
        nm[8*k +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_letter();
    end
    return nm;
  endfunction

  task automatic apb_write(input reg_index_t idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  // Load all four registers; upper bits of the length words are don't-care
  task automatic load_names(input logic [63:0] sect, input int slen,
                            input logic [63:0] key, input int klen);
    apb_write(REG_SECTION_NAME, sect);
    apb_write(REG_SECTION_LENGTH, {32'($urandom()), 28'($urandom()), 4'(slen)});
    apb_write(REG_KEY_NAME, key);
    apb_write(REG_KEY_LENGTH, {32'($urandom()), 28'($urandom()), 4'(klen)});
    psel <= 1'b0;
    penable <= 1'b0;
    cur_sect = sect;
    cur_slen = slen;
    cur_key = key;
    cur_klen = klen;
  endtask

  // Hold the input until every predicted result is out, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic ok;
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++)
      file_bytes.push_back(t[i]);
  endtask

  // how: 0 exact, 1 one byte replaced, 2 one byte short, 3 one byte extra
  task automatic push_name(input logic [63:0] nm, input int len, input int how);
    int n;
    int bad;
    n = (len > 8) ? 8 : len;
    if (how == 2 && n > 0)
      n = n - 1;
    bad = (how == 1 && n > 0) ? $urandom_range(n - 1) : -1;
    for (int k = 0; k < n; k++)
      file_bytes.push_back((k == bad) ? rand_letter() : nm[8*k +: 8]);
    if (how == 3)
      file_bytes.push_back(rand_letter());
  endtask

  function automatic int name_style();
    return ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Mostly well-formed files around the loaded names, with noise and cut-offs
  task automatic build_file();
    int cut;
    int kind;
    file_bytes.delete();
    if ($urandom_range(9) == 0)
      file_bytes.push_back(sep_char());
    if ($urandom_range(99) < 60) begin
      file_bytes.push_back(CH_LBRACK);
      push_name(cur_sect, cur_slen, 0);
      file_bytes.push_back(CH_RBRACK);
      file_bytes.push_back(sep_char());
    end
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        file_bytes.push_back(CH_LBRACK);
        push_name(cur_sect, cur_slen, name_style());
        file_bytes.push_back(CH_RBRACK);
      end else if (kind < 60) begin
        push_name(cur_key, cur_klen, name_style());
        if ($urandom_range(9) == 0)
          file_bytes.push_back(sep_char());
        file_bytes.push_back(CH_EQUAL);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(19))
            0: file_bytes.push_back(CH_LBRACK);
            1: file_bytes.push_back(8'($urandom_range(255)));
            2: file_bytes.push_back(8'h30 + 8'($urandom_range(9)));
            default: file_bytes.push_back(rand_letter());
          endcase
        end
      end else if (kind < 75) begin
        file_bytes.push_back(CH_SEMI);
        repeat ($urandom_range(0, 3)) file_bytes.push_back(rand_letter());
      end else begin
        repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(255)));
      end
      case ($urandom_range(9))
        0: ;
        1: begin
          file_bytes.push_back(sep_char());
          file_bytes.push_back(sep_char());
        end
        default: file_bytes.push_back(sep_char());
      endcase
    end
    // Cut some files short, mid-name or mid-value
    if ($urandom_range(9) == 0 && file_bytes.size() > 1) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut)
        void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: found, bracket where a key should start, empty value, zero key length
    load_names(64'h6261, 2, 64'h6B, 1);
    file_bytes.delete();
    push_text("[ab]\nk=v ");
    send_file();
    file_bytes.delete();
    push_text("[ab]\n[x");
    send_file();
    file_bytes.delete();
    push_text("[ab]\nk=\n");
    send_file();
    wait_idle();
    load_names(64'h6261, 2, 64'h6B, 0);
    file_bytes.delete();
    file_bytes.push_back(8'hFF);
    send_file();
    wait_idle();

    // Random: three idle profiles, each over every register setting
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 18 : (ph == 1) ? 86 : 0;
      rx_idle = (ph == 0) ? 86 : (ph == 1) ? 18 : 0;
      for (int s = 0; s < 7; s++) begin
        load_names(make_name(mode_tab[s]), slen_tab[s], make_name(mode_tab[s]), klen_tab[s]);
        if (ph == 2 && s == 5)
          hold_left = 300;
        sent = 0;
        while (sent < 66) begin
          build_file();
          send_file();
          sent += file_bytes.size();
        end
        wait_idle();
      end
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
